FILE: hdl/rsenc_pkg.sv
// Shared constants, cell control struct and GF(256) arithmetic for the RS encoder.
`timescale 1ns / 1ps

package rsenc_pkg;

	// Number of parity cells in the chain
	localparam int MAX_PARITY = 32;
	// Width of a parity count (holds 0..MAX_PARITY)
	localparam int CNT_W = $clog2(MAX_PARITY + 1);
	// Parity count after reset
	localparam logic [CNT_W-1:0] RESET_PARITY = CNT_W'(8);
	// Field reduction constant, x^8+x^4+x^3+x^2+1
	localparam logic [7:0] GF_REDUCE = 8'h1d;
	// Multiplicative identity, also the implicit leading generator coefficient
	localparam logic [7:0] GF_ONE = 8'h01;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic       build;       // generator build step
		logic       clear_coef;  // start of a build
		logic       clear_rem;   // drop the partial remainder
		logic       absorb;      // a data word enters the remainder
		logic       absorb_last; // that word closes the codeword
		logic       shift_par;   // parity bank moves one cell toward the output
		logic [7:0] root;        // current generator root during a build
	} rsenc_ctrl_t;

	// Multiply by alpha (x)
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
	endfunction

	// GF(256) multiply, shift and add over the bits of b
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				acc = acc ^ sh;
			sh = gf_xtime(sh);
		end
		gf_mul = acc;
	endfunction

endpackage

FILE: hdl/reed_solomon_systematic_encoder_core.sv
// Top level of the systematic Reed-Solomon encoder over GF(256).
`timescale 1ns / 1ps

// Systematic RS encoder, field polynomial x^8+x^4+x^3+x^2+1, generator roots
// alpha^0 .. alpha^(P-1), P = parity_count (1..32, 0 reads as 1, larger as 32).
// Data words are taken one per cycle while in_stall is low; every cell of
// the chain updates its remainder byte with one GF multiply per word. The
// word flagged last_data loads the remainder into a parity bank, which
// shifts out P parity words, highest degree first, one per cycle while
// out_stall is low, as the next codeword's data is already taken in. The
// last data word of a codeword is held off while the bank still holds
// parity words, unless the final one leaves in that same cycle. After
// reset, and after every write of parity_count, the generator is rebuilt
// root by root (P = 8 after reset) by the same cell multipliers; no data
// word is taken during that time. A write of parity_count also clears any
// partially absorbed codeword.
module reed_solomon_systematic_encoder_core
	import rsenc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       parity_count_we,
	input  logic [5:0] parity_count,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] parity_byte,
	output logic       last_parity
);

	rsenc_ctrl_t ctrl;
	logic [7:0]  coef_w [0:MAX_PARITY-1];
	logic [7:0]  rem_w  [0:MAX_PARITY];
	logic [7:0]  par_w  [0:MAX_PARITY];
	logic [7:0]  fb;

	// Sequencer and handshakes
	rsenc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (parity_count_we),
		.cfg_data  (parity_count),
		.in_valid  (in_valid),
		.in_last   (last_data),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_last  (last_parity),
		.ctrl      (ctrl)
	);

	// Chain ends: nothing enters past the top cell
	assign rem_w[MAX_PARITY] = 8'h00;
	assign par_w[MAX_PARITY] = 8'h00;

	// Feedback from the head of the chain
	assign fb          = data_byte ^ rem_w[0];
	assign parity_byte = par_w[0];

	// Row of cells
	for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
		logic [7:0] coef_left;

		if (i == 0) begin : g_head
			assign coef_left = GF_ONE;
		end else begin : g_body
			assign coef_left = coef_w[i-1];
		end

		rsenc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.fb        (fb),
			.coef_left (coef_left),
			.rem_right (rem_w[i+1]),
			.par_right (par_w[i+1]),
			.coef_out  (coef_w[i]),
			.rem_out   (rem_w[i]),
			.par_out   (par_w[i])
		);
	end

endmodule

FILE: hdl/rsenc_cell.sv
// One cell of the encoder chain: generator coefficient, remainder and parity bank.
`timescale 1ns / 1ps

module rsenc_cell
	import rsenc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rsenc_ctrl_t ctrl,
	input  logic [7:0]  fb,         // feedback word, data xor head remainder
	input  logic [7:0]  coef_left,  // coefficient of the cell before (build)
	input  logic [7:0]  rem_right,  // remainder of the cell after
	input  logic [7:0]  par_right,  // parity of the cell after
	output logic [7:0]  coef_out,
	output logic [7:0]  rem_out,
	output logic [7:0]  par_out
);

	logic [7:0] coef_q;
	logic [7:0] rem_q;
	logic [7:0] par_q;
	logic [7:0] mul_a;
	logic [7:0] mul_b;
	logic [7:0] prod;
	logic [7:0] rem_nxt;

	// Shared multiplier: root times left coefficient while building,
	// own coefficient times feedback while encoding
	always_comb begin
		mul_a   = ctrl.build ? coef_left : coef_q;
		mul_b   = ctrl.build ? ctrl.root : fb;
		prod    = gf_mul(mul_a, mul_b);
		rem_nxt = rem_right ^ prod;
	end

	// Generator coefficient: one factor (X + root) per build step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= 8'h00;
		end else if (ctrl.clear_coef) begin
			coef_q <= 8'h00;
		end else if (ctrl.build) begin
			coef_q <= coef_q ^ prod;
		end
	end

	// Remainder register, cleared when a codeword closes or on clear_rem
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 8'h00;
		end else if (ctrl.clear_rem || ctrl.absorb_last) begin
			rem_q <= 8'h00;
		end else if (ctrl.absorb) begin
			rem_q <= rem_nxt;
		end
	end

	// Parity bank: loads the final remainder, then shifts out
	always_ff @(posedge clk) begin
		if (ctrl.absorb_last) begin
			par_q <= rem_nxt;
		end else if (ctrl.shift_par) begin
			par_q <= par_right;
		end
	end

	assign coef_out = coef_q;
	assign rem_out  = rem_q;
	assign par_out  = par_q;

endmodule

FILE: hdl/rsenc_ctrl.sv
// Encoder control: generator build sequencer, parity word count and handshakes.
`timescale 1ns / 1ps

module rsenc_ctrl
	import rsenc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_last,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_last,
	output rsenc_ctrl_t ctrl
);

	logic [CNT_W-1:0] pcount_q;
	logic [CNT_W-1:0] build_cnt_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [7:0]       root_q;
	logic [CNT_W-1:0] cfg_count;
	logic             building;
	logic             bank_free;
	logic             in_acc;
	logic             out_acc;

	// Clamp the written count to 1..MAX_PARITY
	always_comb begin
		if (cfg_data == 6'd0)
			cfg_count = CNT_W'(1);
		else if (32'(cfg_data) > MAX_PARITY)
			cfg_count = CNT_W'(MAX_PARITY);
		else
			cfg_count = CNT_W'(cfg_data);
	end

	// Handshakes; no word is taken while building, and a closing word waits until the parity bank can take it
	always_comb begin
		building  = (build_cnt_q != '0);
		out_valid = (out_cnt_q != '0);
		out_last  = (out_cnt_q == CNT_W'(1));
		bank_free = (out_cnt_q == '0) || (out_last && !out_stall);
		in_stall  = building || (in_last && !bank_free);
		in_acc    = in_valid && !in_stall;
		out_acc   = out_valid && !out_stall;
	end

	// Cell control
	always_comb begin
		ctrl.build       = building;
		ctrl.clear_coef  = cfg_we;
		ctrl.clear_rem   = cfg_we;
		ctrl.absorb      = in_acc;
		ctrl.absorb_last = in_acc && in_last;
		ctrl.shift_par   = out_acc;
		ctrl.root        = root_q;
	end

	// Generator build: one root per cycle, alpha^0 upward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q    <= RESET_PARITY;
			build_cnt_q <= RESET_PARITY;
			root_q      <= GF_ONE;
		end else if (cfg_we) begin
			pcount_q    <= cfg_count;
			build_cnt_q <= cfg_count;
			root_q      <= GF_ONE;
		end else if (building) begin
			build_cnt_q <= build_cnt_q - CNT_W'(1);
			root_q      <= gf_xtime(root_q);
		end
	end

	// Parity words left in the bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (in_acc && in_last) begin
			out_cnt_q <= pcount_q;
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - CNT_W'(1);
		end
	end

	a_out_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= pcount_q)
		else $error("parity count exceeds active parity count");

	a_build_bound: assert property (@(posedge clk) disable iff (!arst_n)
		build_cnt_q <= pcount_q)
		else $error("build counter exceeds active parity count");

	a_pcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pcount_q != '0) && (32'(pcount_q) <= MAX_PARITY))
		else $error("active parity count out of range");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_last && !cfg_we) |=> (out_cnt_q == $past(pcount_q)))
		else $error("parity bank not loaded with full count");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !(in_acc && in_last)) |=> (out_cnt_q == $past(out_cnt_q) - CNT_W'(1)))
		else $error("parity count did not step on output word");

endmodule
